[rtl/iq_block_power_dbfs_meter_macros.svh]
// assertion macros shared by the iq block power meter rtl
// no dependencies; included by modules that carry checks
`ifndef IQ_BLOCK_POWER_DBFS_METER_MACROS_SVH
`define IQ_BLOCK_POWER_DBFS_METER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define IBPM_ASSERT_IMPL(lbl, clock, resetn, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define IBPM_ASSERT_NEXT(lbl, clock, resetn, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ibpm_pkg.sv]
// shared types and constants for the iq block power meter
// no dependencies
package ibpm_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int SAMPLE_W    = 16;
  localparam int SQ_W        = 32;
  localparam int POWER_W     = 16;
  localparam int BLK_CNT_W   = 17;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_LW    = $clog2(FIFO_DEPTH + 1);
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // mean power with 24 fraction bits, always below 2^56
  localparam int FRAC_SH    = 24;
  localparam int XW         = 56;
  localparam int MANT_W     = 31;
  localparam int EXP_W      = 6;
  localparam int NORM_STEPS = 6;
  localparam int NORM_CW    = 3;
  localparam int FRAC_BITS  = 16;
  localparam int LOG_CW     = $clog2(FRAC_BITS);
  localparam int LOG_W      = EXP_W + FRAC_BITS;
  localparam int DIFF_W     = 24;
  localparam int PROD_W     = 51;
  localparam int DB_W       = 19;

  localparam logic [20:0] FLOOR_TERM   = 21'd1801330;
  localparam logic [21:0] LOG_ZERO_REF = 22'd3538938;
  localparam logic [25:0] DB_SCALE     = 26'd50504453;
  localparam logic signed [POWER_W-1:0] DB_MIN = -16'sd25600;
  localparam logic signed [POWER_W-1:0] DB_MAX = 16'sd1024;

  typedef struct packed {
    logic               empty;
    logic [FIFO_LW-1:0] level;
  } fifo_stat_t;

endpackage

[rtl/ibpm_fifo.sv]
// four-entry queue of closed blocks between front and back
// depends on ibpm_pkg and the macros header
`include "iq_block_power_dbfs_meter_macros.svh"

module ibpm_fifo #(
  parameter int W = 65
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  logic [W-1:0]        push_data,
  input  logic                pop,
  output logic [W-1:0]        pop_data,
  output ibpm_pkg::fifo_stat_t stat
);
  import ibpm_pkg::*;

  logic [W-1:0]       mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_LW-1:0] level_r;

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_valid && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (!push_valid && pop) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

  assign pop_data    = mem_r[rd_ptr_r];
  assign stat.empty  = (level_r == '0);
  assign stat.level  = level_r;

  `IBPM_ASSERT_IMPL(a_push_room, clk, rst_n, push_valid, level_r != FIFO_LW'(FIFO_DEPTH), "push into full queue")
  `IBPM_ASSERT_IMPL(a_pop_data, clk, rst_n, pop, level_r != '0, "pop from empty queue")

endmodule

[rtl/ibpm_front.sv]
// sample intake: squares, block energy accumulation and sample counting
// depends on ibpm_pkg; pushes closed blocks into ibpm_fifo
module ibpm_front #(
  parameter int MAX_CNT = 65536,
  parameter int CNT_W   = 17,
  parameter int EW      = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ibpm_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                            in_tlast,
  input  logic                            in_tuser,
  input  ibpm_pkg::fifo_stat_t            fifo_stat,
  output logic                            push_valid,
  output logic [EW+CNT_W-1:0]             push_data
);
  import ibpm_pkg::*;

  logic                       accept;
  logic signed [SAMPLE_W-1:0] si, sq;
  logic signed [SQ_W-1:0]     si2, sq2;
  logic                       room;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt, cnt_inc;
  logic                       p1_valid_r, p1_add_r, p1_last_r;
  logic [CNT_W-1:0]           p1_cnt_r;
  logic [SQ_W-1:0]            p1_sqi_r, p1_sqq_r;
  logic [EW-1:0]              energy_r, energy_sum;

  assign si  = in_tdata[SAMPLE_W-1:0];
  assign sq  = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign si2 = si * si;
  assign sq2 = sq * sq;

  // a closing sample still in the pipe owns one queue slot
  assign in_tready = ({1'b0, fifo_stat.level} + {{FIFO_LW{1'b0}}, p1_valid_r & p1_last_r})
                     < (FIFO_LW + 1)'(FIFO_DEPTH);
  assign accept    = in_tvalid & in_tready;
  assign room      = cnt_r < CNT_W'(MAX_CNT);
  assign cnt_inc   = room ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !in_tuser) begin
      cnt_nxt = in_tlast ? '0 : cnt_inc;
    end
  end

  assign energy_sum = energy_r + (p1_add_r ? EW'(p1_sqi_r) + EW'(p1_sqq_r) : '0);
  assign push_valid = p1_valid_r & p1_last_r;
  assign push_data  = {energy_sum, p1_cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      p1_valid_r <= 1'b0;
      energy_r   <= '0;
    end else begin
      cnt_r      <= cnt_nxt;
      p1_valid_r <= accept & ~in_tuser;
      if (p1_valid_r) begin
        energy_r <= p1_last_r ? '0 : energy_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_add_r  <= room;
      p1_last_r <= in_tlast;
      p1_cnt_r  <= cnt_inc;
      p1_sqi_r  <= si2;
      p1_sqq_r  <= sq2;
    end
  end

endmodule

[rtl/ibpm_back.sv]
// per-block math: mean by long division, log2 by squaring, dBFS scaling, output register
// depends on ibpm_pkg and the macros header; reads blocks from ibpm_fifo
`include "iq_block_power_dbfs_meter_macros.svh"

module ibpm_back #(
  parameter int CNT_W = 17,
  parameter int EW    = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ibpm_pkg::fifo_stat_t             fifo_stat,
  input  logic [EW+CNT_W-1:0]              pop_data,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ibpm_pkg::POWER_W-1:0]     out_power,
  output logic [ibpm_pkg::BLK_CNT_W-1:0]   out_count
);
  import ibpm_pkg::*;

  localparam int DW   = EW + FRAC_SH;
  localparam int IT_W = $clog2(DW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_NORM,
    ST_LOG,
    ST_SCALE,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [DW-1:0]        dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [XW-1:0]        q_r, q_nxt;
  logic [IT_W-1:0]      it_r, it_nxt;
  logic [XW-1:0]        x_r, x_nxt;
  logic [EXP_W-1:0]     sh_r, sh_nxt;
  logic [NORM_CW-1:0]   step_r, step_nxt;
  logic [MANT_W-1:0]    m_r, m_nxt;
  logic [EXP_W-1:0]     p_r, p_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [LOG_CW-1:0]    lc_r, lc_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [POWER_W-1:0]        out_power_r, out_power_nxt;
  logic [BLK_CNT_W-1:0]      out_count_r, out_count_nxt;

  // divider step
  logic [CNT_W:0]   trial, trial_sub;
  logic             ge;
  logic [XW-1:0]    q_step;
  // normalize step
  logic [EXP_W-1:0] nsh;
  logic             top_zero;
  logic [XW-1:0]    x_step;
  logic [EXP_W-1:0] sh_step;
  // log step
  logic [2*MANT_W-1:0] msq;
  logic [MANT_W:0]     msh;
  // scaling
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] rounded;
  logic signed [DB_W-1:0]   db;
  logic signed [DB_W-1:0]   db_lo, db_hi;
  logic [POWER_W-1:0]       db_clamped;
  logic [31:0]              n_ext;
  logic                     out_free;

  assign trial     = {rem_r, dvd_r[DW-1]};
  assign ge        = trial >= {1'b0, n_r};
  assign trial_sub = trial - {1'b0, n_r};
  assign q_step    = {q_r[XW-2:0], ge};

  assign nsh      = EXP_W'(1) << (NORM_STEPS - 1 - int'(step_r));
  assign top_zero = (x_r >> (XW - int'(nsh))) == '0;
  assign x_step   = top_zero ? x_r << nsh : x_r;
  assign sh_step  = top_zero ? sh_r + nsh : sh_r;

  assign msq = m_r * m_r;
  assign msh = msq[2*MANT_W-1:MANT_W-1];

  assign diff    = $signed({2'b00, p_r, frac_r}) - $signed({2'b00, LOG_ZERO_REF});
  assign rounded = prod_r + PROD_W'(64'h8000_0000);
  assign db      = $signed(rounded[PROD_W-1:32]);
  assign db_lo   = DB_W'(DB_MIN);
  assign db_hi   = DB_W'(DB_MAX);

  always_comb begin
    if (db < db_lo) begin
      db_clamped = DB_MIN;
    end else if (db > db_hi) begin
      db_clamped = DB_MAX;
    end else begin
      db_clamped = db[POWER_W-1:0];
    end
  end

  assign n_ext    = 32'(n_r);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    it_nxt        = it_r;
    x_nxt         = x_r;
    sh_nxt        = sh_r;
    step_nxt      = step_r;
    m_nxt         = m_r;
    p_nxt         = p_r;
    frac_nxt      = frac_r;
    lc_nxt        = lc_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_power_nxt = out_power_r;
    out_count_nxt = out_count_r;
    pop           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_stat.empty) begin
          pop       = 1'b1;
          n_nxt     = pop_data[CNT_W-1:0];
          dvd_nxt   = {pop_data[EW+CNT_W-1:CNT_W], {FRAC_SH{1'b0}}};
          rem_nxt   = '0;
          q_nxt     = '0;
          it_nxt    = IT_W'(DW - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        dvd_nxt = dvd_r << 1;
        q_nxt   = q_step;
        it_nxt  = it_r - 1'b1;
        if (it_r == '0) begin
          x_nxt     = q_step + XW'(FLOOR_TERM);
          sh_nxt    = '0;
          step_nxt  = '0;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        x_nxt    = x_step;
        sh_nxt   = sh_step;
        step_nxt = step_r + 1'b1;
        if (step_r == NORM_CW'(NORM_STEPS - 1)) begin
          m_nxt     = x_step[XW-1 -: MANT_W];
          p_nxt     = EXP_W'(XW - 1) - sh_step;
          frac_nxt  = '0;
          lc_nxt    = '0;
          state_nxt = ST_LOG;
        end
      end
      ST_LOG: begin
        if (msh[MANT_W]) begin
          m_nxt    = msh[MANT_W:1];
          frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          m_nxt    = msh[MANT_W-1:0];
          frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b0};
        end
        lc_nxt = lc_r + 1'b1;
        if (lc_r == LOG_CW'(FRAC_BITS - 1)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        prod_nxt  = PROD_W'(diff) * $signed({1'b0, DB_SCALE});
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_power_nxt = db_clamped;
          out_count_nxt = n_ext[BLK_CNT_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      dvd_r       <= dvd_nxt;
      rem_r       <= rem_nxt;
      q_r         <= q_nxt;
      it_r        <= it_nxt;
      x_r         <= x_nxt;
      sh_r        <= sh_nxt;
      step_r      <= step_nxt;
      m_r         <= m_nxt;
      p_r         <= p_nxt;
      frac_r      <= frac_nxt;
      lc_r        <= lc_nxt;
      prod_r      <= prod_nxt;
      out_power_r <= out_power_nxt;
      out_count_r <= out_count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_power  = out_power_r;
  assign out_count  = out_count_r;

  `IBPM_ASSERT_IMPL(a_rem_below_div, clk, rst_n, state_r == ST_DIV, rem_r < n_r, "remainder not below divisor")
  `IBPM_ASSERT_IMPL(a_mant_norm, clk, rst_n, state_r == ST_LOG, m_r[MANT_W-1], "log mantissa not normalized")
  `IBPM_ASSERT_NEXT(a_result_shown, clk, rst_n, state_r == ST_DONE && out_free, out_tvalid && state_r == ST_IDLE, "finished block not presented")

endmodule

[rtl/iq_block_power_dbfs_meter.sv]
// iq block power meter: mean i^2+q^2 per block reported as dBFS in 1/256 dB
// depends on ibpm_pkg, ibpm_front, ibpm_fifo and ibpm_back
// throughput: one sample per cycle while a block accumulates (front squares and adds),
// stalled while the queue has no free slot; the back part takes one block at a time with a
// one-bit-per-cycle divider, 6 normalize steps and 16 log2 squarings; four blocks queue
// closing sample to out_tvalid: front register, queue, divide, normalize, log, scale, output
// rst_n synchronous active low: clears accumulator, count, queue and sequencer
module iq_block_power_dbfs_meter #(
  parameter int MAX_BLOCK_SAMPLES = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ibpm_pkg::IN_TDATA_W-1:0]  in_tdata,   // sample_i, sample_q
  input  logic                             in_tlast,   // last_of_block
  input  logic                             in_tuser,   // skip
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ibpm_pkg::OUT_TDATA_W-1:0] out_tdata   // power_dbfs, block_samples, zero pad
);
  import ibpm_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int EW    = 31 + CNT_W;
  localparam int QW    = EW + CNT_W;

  fifo_stat_t           fifo_stat;
  logic                 push_valid;
  logic [QW-1:0]        push_data;
  logic                 pop;
  logic [QW-1:0]        pop_data;
  logic [POWER_W-1:0]   out_power;
  logic [BLK_CNT_W-1:0] out_count;

  ibpm_front #(
    .MAX_CNT (MAX_BLOCK_SAMPLES),
    .CNT_W   (CNT_W),
    .EW      (EW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .fifo_stat  (fifo_stat),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  ibpm_fifo #(
    .W (QW)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .pop_data   (pop_data),
    .stat       (fifo_stat)
  );

  ibpm_back #(
    .CNT_W (CNT_W),
    .EW    (EW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_power  (out_power),
    .out_count  (out_count)
  );

  assign out_tdata = {{(OUT_TDATA_W - POWER_W - BLK_CNT_W){1'b0}}, out_count, out_power};

endmodule
